>>> src/dlf_pkg.sv
// shared constants and activation tables for the dense layer core
`default_nettype none

package dlf_pkg;

    localparam int MAX_INPUTS_DEF  = 64;
    localparam int MAX_UNITS_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int FRAC_BITS  = 8;
    localparam int ACC_W      = 64;
    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int LUT_W      = 10;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_BIAS   = 2'd1;
    localparam logic [1:0] KIND_ELEM   = 2'd2;

    localparam logic [2:0] ACT_IDENT   = 3'd0;
    localparam logic [2:0] ACT_SIGMOID = 3'd1;
    localparam logic [2:0] ACT_STEP    = 3'd2;
    localparam logic [2:0] ACT_TANH    = 3'd3;
    localparam logic [2:0] ACT_RELU    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sh2000_0000_0000_0000;
    localparam logic signed [LUT_W-1:0] Q_ONE     = 10'sd256;

    // sigmoid of integer part k, indexed k+7
    function automatic logic signed [LUT_W-1:0] sigmoid_lut(input logic [3:0] idx);
        logic signed [LUT_W-1:0] v;
        unique case (idx)
            4'd0:    v = 10'sd0;
            4'd1:    v = 10'sd1;
            4'd2:    v = 10'sd2;
            4'd3:    v = 10'sd5;
            4'd4:    v = 10'sd12;
            4'd5:    v = 10'sd31;
            4'd6:    v = 10'sd69;
            4'd7:    v = 10'sd128;
            4'd8:    v = 10'sd187;
            4'd9:    v = 10'sd225;
            4'd10:   v = 10'sd244;
            4'd11:   v = 10'sd251;
            4'd12:   v = 10'sd254;
            4'd13:   v = 10'sd255;
            4'd14:   v = 10'sd256;
            default: v = 10'sd256;
        endcase
        return v;
    endfunction

    // tanh of integer part k, indexed k+4
    function automatic logic signed [LUT_W-1:0] tanh_lut(input logic [3:0] idx);
        logic signed [LUT_W-1:0] v;
        unique case (idx)
            4'd0:    v = -10'sd256;
            4'd1:    v = -10'sd255;
            4'd2:    v = -10'sd247;
            4'd3:    v = -10'sd195;
            4'd4:    v = 10'sd0;
            4'd5:    v = 10'sd195;
            4'd6:    v = 10'sd247;
            4'd7:    v = 10'sd255;
            4'd8:    v = 10'sd256;
            default: v = 10'sd256;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/dense_layer_forward_core.sv
// dense layer core: y = act(W*x + b) in signed Q8.8 over on-chip weight memory
//
// channels: a command port (start/busy) takes one word per cycle while busy
// is low: a weight load, a bias load or an input element. loads and plain
// elements leave busy low. an element with last set starts the pass and
// raises busy on the next cycle.
// the pass walks the weight memory one word per cycle through a single
// multiply-accumulate unit. the sum of each unit passes through the
// memory read, multiply, accumulate, round and activation registers to
// the result port, one word per unit with o_result_valid high for one
// cycle. the receiver cannot stall.
// after the last unit is read the input vector memory is swept to zero,
// one entry a cycle; busy drops when the sweep is done and the pipeline
// is empty.
// reset runs the same sweep with busy high.
// configuration: write port with valid/ready, always ready, to be written
// only while busy is low and no result is outstanding.
`default_nettype none

module dense_layer_forward_core
    import dlf_pkg::*;
#(
    parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
    parameter int MAX_UNITS   = MAX_UNITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [IDX_W-1:0]              i_row,
    input  wire logic [IDX_W-1:0]              i_col,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    input  wire logic                          i_last,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    // result channel
    output      logic                          o_result_valid,
    output      logic [IDX_W-1:0]              o_unit_index,
    output      logic signed [VALUE_WIDTH-1:0] o_activation_value,
    output      logic                          o_last_unit
);

    // index and counter widths
    localparam int IW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int RW      = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CW      = $clog2(MAX_INPUTS + 1);
    localparam int UCW     = $clog2(MAX_UNITS + 1);
    localparam int W_DEPTH = MAX_UNITS * MAX_INPUTS;
    localparam int WAW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int PW      = 2 * VALUE_WIDTH;
    localparam int CMPW    = ((CW > UCW) ? CW : UCW) + COUNT_W;
    localparam int KW      = VALUE_WIDTH - FRAC_BITS + 5;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO     = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

    localparam logic signed [KW-1:0] K_SIG_LO  = KW'(-7);
    localparam logic signed [KW-1:0] K_SIG_HI  = KW'(7);
    localparam logic signed [KW-1:0] K_TANH_LO = KW'(-4);
    localparam logic signed [KW-1:0] K_TANH_HI = KW'(4);

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // control tag that travels with each multiply slot
    typedef struct packed {
        logic          valid;
        logic          first;
        logic          lastc;
        logic          lastr;
        logic          mac;
        logic [RW-1:0] row;
    } t_slot;

    // configuration registers
    logic [2:0]         r_act_mode;
    logic [COUNT_W-1:0] r_in_count;
    logic [COUNT_W-1:0] r_out_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode  <= ACT_IDENT;
            r_in_count  <= COUNT_W'(64);
            r_out_count <= COUNT_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ACT:       r_act_mode  <= i_cfg_data[2:0];
                CFG_IN_COUNT:  r_in_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_OUT_COUNT: r_out_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer registers
    logic [1:0]     r_state;
    logic [CW-1:0]  r_ni;
    logic [UCW-1:0] r_nu;
    logic [CW-1:0]  r_col;
    logic [UCW-1:0] r_row;
    logic [WAW-1:0] r_wbase;
    logic [CW-1:0]  r_clr;

    // command decode
    logic                 in_acc;
    logic [RW+IDX_W-1:0]  row_wide;
    logic [IW+IDX_W-1:0]  col_wide;
    logic                 row_ok;
    logic                 col_ok;
    logic [RW-1:0]        ld_row;
    logic [IW-1:0]        ld_col;
    logic [WAW-1:0]       ld_waddr;
    logic                 go;

    assign busy     = (r_state != ST_IDLE);
    assign in_acc   = start && !busy;
    assign row_wide = (RW + IDX_W)'(i_row);
    assign col_wide = (IW + IDX_W)'(i_col);
    assign row_ok   = row_wide < (RW + IDX_W)'(MAX_UNITS);
    assign col_ok   = col_wide < (IW + IDX_W)'(MAX_INPUTS);
    assign ld_row   = row_wide[RW-1:0];
    assign ld_col   = col_wide[IW-1:0];
    assign ld_waddr = WAW'(ld_row) * WAW'(MAX_INPUTS) + WAW'(ld_col);
    assign go       = in_acc && (i_kind == KIND_ELEM) && i_last;

    // counts clipped to the memory sizes
    logic [CMPW-1:0] ni_full, nu_full, ni_sat, nu_sat;

    assign ni_full = CMPW'(r_in_count);
    assign nu_full = CMPW'(r_out_count);
    assign ni_sat  = (ni_full > CMPW'(MAX_INPUTS)) ? CMPW'(MAX_INPUTS) : ni_full;
    assign nu_sat  = (nu_full > CMPW'(MAX_UNITS)) ? CMPW'(MAX_UNITS) : nu_full;

    // slot issue
    logic  slot_lastc;
    logic  slot_lastr;
    logic  clr_last;
    logic  pipe_busy;
    t_slot s0;

    assign slot_lastc = (r_ni == '0) || ((r_col + CW'(1)) == r_ni);
    assign slot_lastr = (r_row + UCW'(1)) == r_nu;
    assign clr_last   = (r_clr == CW'(MAX_INPUTS - 1));

    always_comb begin
        s0.valid = (r_state == ST_RUN);
        s0.first = (r_col == '0);
        s0.lastc = slot_lastc;
        s0.lastr = slot_lastr;
        s0.mac   = (r_ni != '0);
        s0.row   = r_row[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_wbase <= '0;
            r_ni    <= '0;
            r_nu    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (go) begin
                        r_ni    <= ni_sat[CW-1:0];
                        r_nu    <= nu_sat[UCW-1:0];
                        r_col   <= '0;
                        r_row   <= '0;
                        r_wbase <= '0;
                        r_clr   <= '0;
                        r_state <= (nu_sat == '0) ? ST_CLEAR : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (slot_lastc) begin
                        r_col   <= '0;
                        r_row   <= r_row + UCW'(1);
                        r_wbase <= r_wbase + WAW'(MAX_INPUTS);
                        if (slot_lastr) begin
                            r_state <= ST_CLEAR;
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                ST_CLEAR: begin
                    // hold on the last entry until the pipeline has drained
                    if (clr_last) begin
                        if (!pipe_busy) begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_clr <= r_clr + CW'(1);
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    // weight memory
    logic signed [VALUE_WIDTH-1:0] weight_mem [W_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_w_q;
    logic [WAW-1:0]                w_raddr;

    assign w_raddr = r_wbase + WAW'(r_col[IW-1:0]);

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_WEIGHT) && row_ok && col_ok) begin
            weight_mem[ld_waddr] <= i_value;
        end
        r_w_q <= weight_mem[w_raddr];
    end

    // bias memory
    logic signed [VALUE_WIDTH-1:0] bias_mem [MAX_UNITS];
    logic signed [VALUE_WIDTH-1:0] r_b_q;

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_BIAS) && row_ok) begin
            bias_mem[ld_row] <= i_value;
        end
        r_b_q <= bias_mem[r_row[RW-1:0]];
    end

    // input vector memory, zeroed by the sweep
    logic signed [VALUE_WIDTH-1:0] input_mem [MAX_INPUTS];
    logic signed [VALUE_WIDTH-1:0] r_x_q;
    logic                          x_we;
    logic [IW-1:0]                 x_waddr;
    logic signed [VALUE_WIDTH-1:0] x_wdata;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            x_we    = 1'b1;
            x_waddr = r_clr[IW-1:0];
            x_wdata = '0;
        end else begin
            x_we    = in_acc && (i_kind == KIND_ELEM) && col_ok;
            x_waddr = ld_col;
            x_wdata = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            input_mem[x_waddr] <= x_wdata;
        end
        r_x_q <= input_mem[r_col[IW-1:0]];
    end

    // stage 1: memory data, multiply
    t_slot                  r_s1, r_s2;
    logic signed [PW-1:0]   r_prod;
    logic signed [VALUE_WIDTH-1:0] r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= s0;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_w_q * r_x_q;
        r_bias <= r_b_q;
    end

    // stage 2: accumulate with clamp at the accumulator limit
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] acc_base, acc_sum, n_acc;

    always_comb begin
        acc_base = r_s2.first ? (ACC_W'(r_bias) <<< FRAC_BITS) : r_acc;
        acc_sum  = acc_base + (r_s2.mac ? ACC_W'(r_prod) : '0);
        if (acc_sum > ACC_LIMIT) begin
            n_acc = ACC_LIMIT;
        end else if (acc_sum < -ACC_LIMIT) begin
            n_acc = -ACC_LIMIT;
        end else begin
            n_acc = acc_sum;
        end
    end

    logic                    r_fin_v;
    logic signed [ACC_W-1:0] r_fin_acc;
    logic [RW-1:0]           r_fin_row;
    logic                    r_fin_lastr;

    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
        r_fin_acc   <= n_acc;
        r_fin_row   <= r_s2.row;
        r_fin_lastr <= r_s2.lastr;
    end

    // stage 3: round half up, saturate to the value width
    logic signed [ACC_W-1:0]       rnd_sum, rnd_q;
    logic signed [VALUE_WIDTH-1:0] n_sat;

    always_comb begin
        rnd_sum = r_fin_acc + ROUND_HALF;
        rnd_q   = rnd_sum >>> FRAC_BITS;
        if (rnd_q > SAT_HI) begin
            n_sat = SAT_HI[VALUE_WIDTH-1:0];
        end else if (rnd_q < SAT_LO) begin
            n_sat = SAT_LO[VALUE_WIDTH-1:0];
        end else begin
            n_sat = rnd_q[VALUE_WIDTH-1:0];
        end
    end

    logic                          r_sat_v;
    logic signed [VALUE_WIDTH-1:0] r_sat;
    logic [RW-1:0]                 r_sat_row;
    logic                          r_sat_lastr;

    always_ff @(posedge i_clk) begin
        r_sat       <= n_sat;
        r_sat_row   <= r_fin_row;
        r_sat_lastr <= r_fin_lastr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v        <= 1'b0;
            r_sat_v        <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_fin_v        <= r_s2.valid && r_s2.lastc;
            r_sat_v        <= r_fin_v;
            o_result_valid <= r_sat_v;
        end
    end

    assign pipe_busy = r_s1.valid || r_s2.valid || r_fin_v || r_sat_v;

    // stage 4: activation
    logic signed [KW-1:0]          act_k;
    logic signed [KW-1:0]          sig_k, tanh_k;
    logic signed [LUT_W-1:0]       lut_v;
    logic signed [VALUE_WIDTH+LUT_W-1:0] lut_wide, one_wide;
    logic signed [VALUE_WIDTH-1:0] n_act;
    logic [RW+IDX_W-1:0]           out_row_wide;

    always_comb begin
        act_k  = KW'(r_sat >>> FRAC_BITS);
        sig_k  = (act_k < K_SIG_LO) ? K_SIG_LO : ((act_k > K_SIG_HI) ? K_SIG_HI : act_k);
        tanh_k = (act_k < K_TANH_LO) ? K_TANH_LO
               : ((act_k > K_TANH_HI) ? K_TANH_HI : act_k);
        if (r_act_mode == ACT_TANH) begin
            lut_v = tanh_lut(4'(tanh_k - K_TANH_LO));
        end else begin
            lut_v = sigmoid_lut(4'(sig_k - K_SIG_LO));
        end
        lut_wide = (VALUE_WIDTH + LUT_W)'(lut_v);
        one_wide = (VALUE_WIDTH + LUT_W)'(Q_ONE);
        unique case (r_act_mode)
            ACT_IDENT:   n_act = r_sat;
            ACT_SIGMOID: n_act = lut_wide[VALUE_WIDTH-1:0];
            ACT_STEP:    n_act = (r_sat > 0) ? one_wide[VALUE_WIDTH-1:0] : '0;
            ACT_TANH:    n_act = lut_wide[VALUE_WIDTH-1:0];
            ACT_RELU:    n_act = r_sat[VALUE_WIDTH-1] ? '0 : r_sat;
            default:     n_act = r_sat;
        endcase
    end

    assign out_row_wide = (RW + IDX_W)'(r_sat_row);

    always_ff @(posedge i_clk) begin
        o_unit_index       <= out_row_wide[IDX_W-1:0];
        o_activation_value <= n_act;
        o_last_unit        <= r_sat_lastr;
    end

endmodule

`default_nettype wire
